// ===== design/masked_signature_scanner_core_macros.svh =====
// assertion macros for the signature scanner
// both forms use clk of the including module; MSS_ASSERT also uses its arst_n
`ifndef MASKED_SIGNATURE_SCANNER_CORE_MACROS_SVH
`define MASKED_SIGNATURE_SCANNER_CORE_MACROS_SVH

`ifndef ASSERT_OFF

// check a property on every clock edge outside reset
`define MSS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// check a property on every clock edge, reset included
`define MSS_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define MSS_ASSERT(lbl, prop, msg)
`define MSS_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// ===== design/mss_pkg.sv =====
`timescale 1ns / 1ps

package mss_pkg;

	// pattern table depth and stream position width
	localparam int MAX_SPAN   = 512;
	localparam int SPAN_IDX_W = $clog2(MAX_SPAN);
	localparam int POS_W      = 32;

	// field widths
	localparam int SPAN_CFG_W  = 10;
	localparam int START_W     = 32;
	localparam int LIMIT_W     = 8;
	localparam int ENTRY_W     = 9;
	localparam int BYTE_W      = 8;
	localparam int BASE_W      = 32;
	localparam int TOTAL_W     = 8;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 32;

	localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

	// request kinds
	typedef enum logic {
		REQ_LOAD = 1'b0,
		REQ_DATA = 1'b1
	} req_kind_t;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SPAN  = 2'd0,
		CFG_START = 2'd1,
		CFG_LIMIT = 2'd2
	} cfg_reg_t;

	// one input item
	typedef struct packed {
		logic              req_type;
		logic [ENTRY_W-1:0] entry_index;
		logic [BYTE_W-1:0]  entry_byte;
		logic               entry_care;
		logic [BYTE_W-1:0]  data_byte;
		logic               last_byte;
	} req_t;

	// one result item
	typedef struct packed {
		logic               match_valid;
		logic [BASE_W-1:0]  match_base;
		logic               stream_end;
		logic [TOTAL_W-1:0] match_total;
	} res_t;

endpackage

// ===== design/mss_if.sv =====
`timescale 1ns / 1ps

// request channel
interface mss_req_if;
	logic                          valid;
	logic                          ready;
	logic                          req_type;
	logic [mss_pkg::ENTRY_W-1:0]   entry_index;
	logic [mss_pkg::BYTE_W-1:0]    entry_byte;
	logic                          entry_care;
	logic [mss_pkg::BYTE_W-1:0]    data_byte;
	logic                          last_byte;

	modport source (output valid, req_type, entry_index, entry_byte, entry_care,
		data_byte, last_byte, input ready);
	modport sink (input valid, req_type, entry_index, entry_byte, entry_care,
		data_byte, last_byte, output ready);
endinterface

// result channel
interface mss_res_if;
	logic                          valid;
	logic                          ready;
	logic                          match_valid;
	logic [mss_pkg::BASE_W-1:0]    match_base;
	logic                          stream_end;
	logic [mss_pkg::TOTAL_W-1:0]   match_total;

	modport source (output valid, match_valid, match_base, stream_end, match_total,
		input ready);
	modport sink (input valid, match_valid, match_base, stream_end, match_total,
		output ready);
endinterface

// configuration write channel
interface mss_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [mss_pkg::CFG_IDX_W-1:0]   index;
	logic [mss_pkg::CFG_DATA_W-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== design/masked_signature_scanner_core.sv =====
`timescale 1ns / 1ps
// Wildcard byte pattern scanner.
// req channel: a beat with req_type 0 loads one pattern entry (byte and care
// bit at entry_index); a beat with req_type 1 delivers one stream byte, with
// last_byte marking the end of the stream.
// res channel: a beat is sent for a data byte that completes a reported match
// or that ends the stream; load beats and other data bytes give none.
// cfg channel: register writes (span, start offset, match limit), always ready;
// writes are to be taken while the block is idle: the user must ensure it, the block does not enforce it.
// Path: a request beat is registered in the input register, then evaluated
// combinationally against the whole pattern table; its result is written
// into the output register, which drives res.valid.
// Throughput: one request beat per cycle while the result path does not stall;
// the shift-and compare of all table entries against the byte is done in parallel.
// Reset clears care bits, the match vector, the stream position, the match
// count and the registers (span 1, start 0, no limit).
// When the receiver stalls, the result waits in the output register; loads and
// quiet data bytes keep flowing, while a beat with a result waits in the input
// register and req.ready stays low until the output register is taken.
module masked_signature_scanner_core (
	input  logic              clk,
	input  logic              arst_n,
	mss_req_if.sink           req,
	mss_res_if.source         res,
	mss_cfg_if.sink           cfg
);

	// configuration registers
	logic [mss_pkg::SPAN_CFG_W-1:0] span_q;
	logic [mss_pkg::START_W-1:0]    start_q;
	logic [mss_pkg::LIMIT_W-1:0]    limit_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			span_q  <= mss_pkg::SPAN_CFG_W'(1);
			start_q <= '0;
			limit_q <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				mss_pkg::CFG_SPAN:  span_q  <= mss_pkg::SPAN_CFG_W'(cfg.data);
				mss_pkg::CFG_START: start_q <= mss_pkg::START_W'(cfg.data);
				mss_pkg::CFG_LIMIT: limit_q <= mss_pkg::LIMIT_W'(cfg.data);
				default: ;
			endcase
		end
	end

	// input register
	logic          s1_valid_q;
	mss_pkg::req_t item_s1;
	logic          s1_adv;
	logic          req_fire;

	assign req.ready = !s1_valid_q || s1_adv;
	assign req_fire  = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (req.ready) begin
			s1_valid_q <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			item_s1 <= '{req_type: req.req_type, entry_index: req.entry_index,
				entry_byte: req.entry_byte, entry_care: req.entry_care,
				data_byte: req.data_byte, last_byte: req.last_byte};
		end
	end

	// pattern table and stream state
	logic [mss_pkg::BYTE_W-1:0]     pat_q [mss_pkg::MAX_SPAN];
	logic [mss_pkg::MAX_SPAN-1:0]   care_q;
	logic [mss_pkg::MAX_SPAN-1:0]   pm_q;
	logic [mss_pkg::POS_W-1:0]      pos_q;
	logic [mss_pkg::TOTAL_W-1:0]    count_q;

	// per-entry mismatch against the current byte
	logic [mss_pkg::MAX_SPAN-1:0] miss;
	always_comb begin
		for (int i = 0; i < mss_pkg::MAX_SPAN; i++) begin
			miss[i] = care_q[i] && (pat_q[i] != item_s1.data_byte);
		end
	end

	// shift-and update
	logic [mss_pkg::MAX_SPAN-1:0] pm_next;
	assign pm_next = {pm_q[mss_pkg::MAX_SPAN-2:0], 1'b1} & ~miss;

	// top offset of the pattern, span clamped to the table
	logic [mss_pkg::SPAN_IDX_W-1:0] top;
	always_comb begin
		priority if (span_q == '0) begin
			top = '0;
		end else if (32'(span_q) > mss_pkg::MAX_SPAN) begin
			top = mss_pkg::SPAN_IDX_W'(mss_pkg::MAX_SPAN - 1);
		end else begin
			top = mss_pkg::SPAN_IDX_W'(span_q - mss_pkg::SPAN_CFG_W'(1));
		end
	end

	// match decision
	logic                          is_data;
	logic                          done;
	logic [mss_pkg::POS_W-1:0]     base;
	logic                          report;
	logic [mss_pkg::TOTAL_W-1:0]   count_next;
	logic                          emit;

	assign is_data = item_s1.req_type == mss_pkg::REQ_DATA;
	assign done    = pm_next[top];
	assign base    = pos_q - mss_pkg::POS_W'(top);
	assign report  = done && (64'(base) >= 64'(start_q))
		&& (limit_q == '0 || count_q < mss_pkg::TOTAL_W'(limit_q));
	assign count_next = (report && count_q != mss_pkg::TOTAL_MAX)
		? count_q + mss_pkg::TOTAL_W'(1) : count_q;
	assign emit = is_data && (report || item_s1.last_byte);

	// the item moves on unless its result has nowhere to go
	logic res_valid_q;
	assign s1_adv = s1_valid_q && (!emit || !res_valid_q || res.ready);

	// table writes
	always_ff @(posedge clk) begin
		if (s1_adv && !is_data && 32'(item_s1.entry_index) < mss_pkg::MAX_SPAN) begin
			pat_q[mss_pkg::SPAN_IDX_W'(item_s1.entry_index)] <= item_s1.entry_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			care_q <= '0;
		end else if (s1_adv && !is_data
			&& 32'(item_s1.entry_index) < mss_pkg::MAX_SPAN) begin
			care_q[mss_pkg::SPAN_IDX_W'(item_s1.entry_index)] <= item_s1.entry_care;
		end
	end

	// stream state, restarted after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pm_q    <= '0;
			pos_q   <= '0;
			count_q <= '0;
		end else if (s1_adv && is_data) begin
			if (item_s1.last_byte) begin
				pm_q    <= '0;
				pos_q   <= '0;
				count_q <= '0;
			end else begin
				pm_q    <= pm_next;
				pos_q   <= pos_q + mss_pkg::POS_W'(1);
				count_q <= count_next;
			end
		end
	end

	// result register
	mss_pkg::res_t res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (s1_adv && emit) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && emit) begin
			res_q.match_valid <= report;
			res_q.match_base  <= report ? mss_pkg::BASE_W'(base) : '0;
			res_q.stream_end  <= item_s1.last_byte;
			res_q.match_total <= count_next;
		end
	end

	assign res.valid       = res_valid_q;
	assign res.match_valid = res_q.match_valid;
	assign res.match_base  = res_q.match_base;
	assign res.stream_end  = res_q.stream_end;
	assign res.match_total = res_q.match_total;

	// checks
`include "masked_signature_scanner_core_macros.svh"

	`MSS_ASSERT(a_match_counted, res.valid && res.match_valid |-> res.match_total != '0, "reported match with zero total")
	`MSS_ASSERT(a_res_has_cause, res.valid && !res.match_valid |-> res.stream_end, "result beat without match or stream end")
	`MSS_ASSERT(a_restart, s1_adv && is_data && item_s1.last_byte |=> pos_q == '0 && pm_q == '0 && count_q == '0, "stream state not cleared after last byte")
	`MSS_ASSERT(a_no_overrun, s1_valid_q && !s1_adv |-> !req.ready, "input register overrun")

endmodule
